/* rtl/hsv_to_rgb_converter_defines.svh */
// Assertion macros shared by the converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hsvrgb_pkg.sv */
// Constants, types and tables for the HSV to RGB converter.
package hsvrgb_pkg;

    // Fixed-point formats
    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 8;
    localparam int HUE_W          = 16;
    localparam int UNIT_W         = 10;
    localparam int CHAN_W         = 8;

    // 1.0 for saturation and value, and the clamped width (0..ONE)
    localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;
    localparam int CLAMP_W  = UNIT_FRAC_BITS + 1;

    // One 120 degree sector in hue units
    localparam int SECTOR_LEN = 120 << HUE_FRAC_BITS;
    localparam int FRAC_W     = $clog2(SECTOR_LEN);
    localparam int RAMP_W     = FRAC_W + 1;

    // Whole sectors added so that the most negative hue becomes non-negative
    localparam int OFFSET_SECT = (2 ** (HUE_W - 1) + SECTOR_LEN - 1) / SECTOR_LEN;
    localparam int HUE_OFFSET  = OFFSET_SECT * SECTOR_LEN;
    localparam int U_W         = $clog2(HUE_OFFSET + 2 ** (HUE_W - 1));
    localparam int NUM_THRESH  = (HUE_OFFSET + 2 ** (HUE_W - 1) - 1) / SECTOR_LEN;
    localparam int Q_W         = $clog2(NUM_THRESH + 1);

    // Mix term (ONE-s)*P + s*R and the product with value
    localparam int MIX_W  = $clog2(UNIT_ONE * SECTOR_LEN + 1);
    localparam int PROD_W = MIX_W + CLAMP_W;

    // 255 / (ONE*ONE*P) reduces to 17 / 2^25 for these formats
    localparam int SCALE_MUL   = 17;
    localparam int SCALE_SHIFT = 25;
    localparam int SCALED_W    = PROD_W + 5;

    // Pipeline depth
    localparam int NUM_STAGES = 7;

    // Channel rotation by sector mod 3
    typedef enum logic [1:0] {
        ROT_0 = 2'd0,
        ROT_1 = 2'd1,
        ROT_2 = 2'd2
    } t_rot;

    // Per-stage handshake control
    typedef struct packed {
        logic                  in_ready;
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctrl;

    // Clamp a signed unit value to 0..ONE
    function automatic logic [CLAMP_W-1:0] clamp_unit(input logic signed [UNIT_W-1:0] x);
        logic [CLAMP_W-1:0] res;
        if (x[UNIT_W-1]) begin
            res = '0;
        end else if (x > UNIT_W'(UNIT_ONE)) begin
            res = CLAMP_W'(UNIT_ONE);
        end else begin
            res = x[CLAMP_W-1:0];
        end
        return res;
    endfunction

    // Rotation of an offset sector index: (q - OFFSET_SECT) mod 3
    function automatic t_rot sector_rot(input logic [Q_W-1:0] q);
        t_rot res;
        case (q)
            4'd0:    res = ROT_1;
            4'd1:    res = ROT_2;
            4'd2:    res = ROT_0;
            4'd3:    res = ROT_1;
            4'd4:    res = ROT_2;
            4'd5:    res = ROT_0;
            4'd6:    res = ROT_1;
            4'd7:    res = ROT_2;
            4'd8:    res = ROT_0;
            4'd9:    res = ROT_1;
            default: res = ROT_0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/hsvrgb_if.sv */
// Valid/ready channel interfaces for HSV requests and RGB results.
interface hsvrgb_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hsvrgb_pkg::HUE_W-1:0]  hue;
    logic signed [hsvrgb_pkg::UNIT_W-1:0] saturation;
    logic signed [hsvrgb_pkg::UNIT_W-1:0] brightness;
    logic                                layer_select;

    modport source (output valid, hue, saturation, brightness, layer_select, input ready);
    modport sink   (input valid, hue, saturation, brightness, layer_select, output ready);
endinterface

interface hsvrgb_out_if;
    logic                              valid;
    logic                              ready;
    logic [hsvrgb_pkg::CHAN_W-1:0]     red;
    logic [hsvrgb_pkg::CHAN_W-1:0]     green;
    logic [hsvrgb_pkg::CHAN_W-1:0]     blue;
    logic                              layer_flag;

    modport source (output valid, red, green, blue, layer_flag, input ready);
    modport sink   (input valid, red, green, blue, layer_flag, output ready);
endinterface

/* rtl/hsvrgb_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the converter pipeline.
module hsvrgb_pipe_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_out_ready,
    output hsvrgb_pkg::t_pipe_ctrl o_ctrl
);

    localparam int N = hsvrgb_pkg::NUM_STAGES;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] w_rdy;

    // A stage takes a request when it is empty or its own request moves on
    always_comb begin
        w_rdy[N-1] = !r_vld[N-1] || i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Valid bits follow the data
    always_comb begin
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < N; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctrl.in_ready = w_rdy[0];
    assign o_ctrl.load     = w_rdy;
    assign o_ctrl.valid    = r_vld;

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, seven-stage pipeline with valid/ready channels.
// An accepted request passes through the stage registers 0 to 6 before its result reaches the output.
// Throughput: one request per cycle; stalls back up stage by stage and
// empty stages keep accepting while a result waits at the output.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsvrgb_in_if.sink     i_in,
    hsvrgb_out_if.source  o_out
);

    localparam int CLAMP_W  = hsvrgb_pkg::CLAMP_W;
    localparam int U_W      = hsvrgb_pkg::U_W;
    localparam int Q_W      = hsvrgb_pkg::Q_W;
    localparam int FRAC_W   = hsvrgb_pkg::FRAC_W;
    localparam int RAMP_W   = hsvrgb_pkg::RAMP_W;
    localparam int MIX_W    = hsvrgb_pkg::MIX_W;
    localparam int PROD_W   = hsvrgb_pkg::PROD_W;
    localparam int SCALED_W = hsvrgb_pkg::SCALED_W;
    localparam int CHAN_W   = hsvrgb_pkg::CHAN_W;
    localparam int HUE_W    = hsvrgb_pkg::HUE_W;

    hsvrgb_pkg::t_pipe_ctrl s_ctrl;

    hsvrgb_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (s_ctrl)
    );

    assign i_in.ready = s_ctrl.in_ready;

    // Stage 0: clamp saturation and value, offset hue to non-negative
    logic [CLAMP_W-1:0] r_s0_sat, r_s0_val;
    logic [U_W-1:0]     r_s0_hue;
    logic               r_s0_layer;

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[0]) begin
            r_s0_sat   <= hsvrgb_pkg::clamp_unit(i_in.saturation);
            r_s0_val   <= hsvrgb_pkg::clamp_unit(i_in.brightness);
            r_s0_hue   <= {{(U_W - HUE_W){i_in.hue[HUE_W-1]}}, i_in.hue}
                          + U_W'(hsvrgb_pkg::HUE_OFFSET);
            r_s0_layer <= i_in.layer_select;
        end
    end

    // Stage 1: sector index by threshold compares, fraction within sector
    logic [Q_W-1:0]    w_sect;
    logic [U_W-1:0]    w_frac_full;
    logic [FRAC_W-1:0] r_s1_frac;
    hsvrgb_pkg::t_rot  r_s1_rot;
    logic [CLAMP_W-1:0] r_s1_sat, r_s1_val;
    logic               r_s1_layer;

    always_comb begin
        w_sect = '0;
        for (int k = 1; k <= hsvrgb_pkg::NUM_THRESH; k++) begin
            if (r_s0_hue >= U_W'(k * hsvrgb_pkg::SECTOR_LEN)) begin
                w_sect = w_sect + Q_W'(1);
            end
        end
        w_frac_full = r_s0_hue - U_W'(U_W'(w_sect) * U_W'(hsvrgb_pkg::SECTOR_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[1]) begin
            r_s1_frac  <= w_frac_full[FRAC_W-1:0];
            r_s1_rot   <= hsvrgb_pkg::sector_rot(w_sect);
            r_s1_sat   <= r_s0_sat;
            r_s1_val   <= r_s0_val;
            r_s1_layer <= r_s0_layer;
        end
    end

    // Stage 2: falling and rising ramps, each capped at one sector
    logic [RAMP_W-1:0]  w_fall2, w_rise2;
    logic [FRAC_W-1:0]  r_s2_fall, r_s2_rise;
    hsvrgb_pkg::t_rot   r_s2_rot;
    logic [CLAMP_W-1:0] r_s2_sat, r_s2_val;
    logic               r_s2_layer;

    always_comb begin
        w_fall2 = {FRAC_W'(hsvrgb_pkg::SECTOR_LEN) - r_s1_frac, 1'b0};
        w_rise2 = {r_s1_frac, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[2]) begin
            r_s2_fall  <= (w_fall2 < RAMP_W'(hsvrgb_pkg::SECTOR_LEN))
                          ? w_fall2[FRAC_W-1:0] : FRAC_W'(hsvrgb_pkg::SECTOR_LEN);
            r_s2_rise  <= (w_rise2 < RAMP_W'(hsvrgb_pkg::SECTOR_LEN))
                          ? w_rise2[FRAC_W-1:0] : FRAC_W'(hsvrgb_pkg::SECTOR_LEN);
            r_s2_rot   <= r_s1_rot;
            r_s2_sat   <= r_s1_sat;
            r_s2_val   <= r_s1_val;
            r_s2_layer <= r_s1_layer;
        end
    end

    // Stage 3: s*ramp products and the (1-s)*P base term
    logic [CLAMP_W+FRAC_W-1:0] w_p_fall, w_p_rise, w_base;
    logic [CLAMP_W-1:0]        w_one_minus_s;
    logic [MIX_W-1:0]          r_s3_pfall, r_s3_prise, r_s3_base;
    hsvrgb_pkg::t_rot          r_s3_rot;
    logic [CLAMP_W-1:0]        r_s3_val;
    logic                      r_s3_layer;

    always_comb begin
        w_one_minus_s = CLAMP_W'(hsvrgb_pkg::UNIT_ONE) - r_s2_sat;
        w_p_fall = (CLAMP_W + FRAC_W)'(r_s2_sat) * (CLAMP_W + FRAC_W)'(r_s2_fall);
        w_p_rise = (CLAMP_W + FRAC_W)'(r_s2_sat) * (CLAMP_W + FRAC_W)'(r_s2_rise);
        w_base   = (CLAMP_W + FRAC_W)'(w_one_minus_s)
                   * (CLAMP_W + FRAC_W)'(hsvrgb_pkg::SECTOR_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[3]) begin
            r_s3_pfall <= w_p_fall[MIX_W-1:0];
            r_s3_prise <= w_p_rise[MIX_W-1:0];
            r_s3_base  <= w_base[MIX_W-1:0];
            r_s3_rot   <= r_s2_rot;
            r_s3_val   <= r_s2_val;
            r_s3_layer <= r_s2_layer;
        end
    end

    // Stage 4: mix terms for the three channels (third ramp is zero)
    logic [MIX_W-1:0]   r_s4_mix0, r_s4_mix1, r_s4_mix2;
    hsvrgb_pkg::t_rot   r_s4_rot;
    logic [CLAMP_W-1:0] r_s4_val;
    logic               r_s4_layer;

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[4]) begin
            r_s4_mix0  <= r_s3_base + r_s3_pfall;
            r_s4_mix1  <= r_s3_base + r_s3_prise;
            r_s4_mix2  <= r_s3_base;
            r_s4_rot   <= r_s3_rot;
            r_s4_val   <= r_s3_val;
            r_s4_layer <= r_s3_layer;
        end
    end

    // Stage 5: multiply by value
    logic [PROD_W-1:0] r_s5_w0, r_s5_w1, r_s5_w2;
    hsvrgb_pkg::t_rot  r_s5_rot;
    logic              r_s5_layer;

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[5]) begin
            r_s5_w0    <= PROD_W'(r_s4_val) * PROD_W'(r_s4_mix0);
            r_s5_w1    <= PROD_W'(r_s4_val) * PROD_W'(r_s4_mix1);
            r_s5_w2    <= PROD_W'(r_s4_val) * PROD_W'(r_s4_mix2);
            r_s5_rot   <= r_s4_rot;
            r_s5_layer <= r_s4_layer;
        end
    end

    // Stage 6: scale by 255/(ONE*ONE*P) as x*17 >> 25, then rotate into RGB
    logic [SCALED_W-1:0] w_sc0, w_sc1, w_sc2;
    logic [CHAN_W-1:0]   w_c0, w_c1, w_c2;
    logic [CHAN_W-1:0]   n_red, n_green, n_blue;
    logic [CHAN_W-1:0]   r_red, r_green, r_blue;
    logic                r_layer;

    always_comb begin
        w_sc0 = SCALED_W'(r_s5_w0) * SCALED_W'(hsvrgb_pkg::SCALE_MUL);
        w_sc1 = SCALED_W'(r_s5_w1) * SCALED_W'(hsvrgb_pkg::SCALE_MUL);
        w_sc2 = SCALED_W'(r_s5_w2) * SCALED_W'(hsvrgb_pkg::SCALE_MUL);
        w_c0  = w_sc0[hsvrgb_pkg::SCALE_SHIFT +: CHAN_W];
        w_c1  = w_sc1[hsvrgb_pkg::SCALE_SHIFT +: CHAN_W];
        w_c2  = w_sc2[hsvrgb_pkg::SCALE_SHIFT +: CHAN_W];
        case (r_s5_rot)
            hsvrgb_pkg::ROT_0: begin
                n_red = w_c0; n_green = w_c1; n_blue = w_c2;
            end
            hsvrgb_pkg::ROT_1: begin
                n_red = w_c2; n_green = w_c0; n_blue = w_c1;
            end
            hsvrgb_pkg::ROT_2: begin
                n_red = w_c1; n_green = w_c2; n_blue = w_c0;
            end
            default: begin
                n_red = w_c0; n_green = w_c1; n_blue = w_c2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_layer <= r_s5_layer;
        end
    end

    // Result channel
    assign o_out.valid      = s_ctrl.valid[hsvrgb_pkg::NUM_STAGES-1];
    assign o_out.red        = r_red;
    assign o_out.green      = r_green;
    assign o_out.blue       = r_blue;
    assign o_out.layer_flag = r_layer;

    // Checks on the datapath and the stage handoff
    `HSVRGB_ASSERT_IMPLY(a_frac_in_sector, i_clk, i_rst_n, s_ctrl.valid[1], r_s1_frac < FRAC_W'(hsvrgb_pkg::SECTOR_LEN), "hue fraction outside its sector")
    `HSVRGB_ASSERT_IMPLY(a_one_ramp_full, i_clk, i_rst_n, s_ctrl.valid[2], (r_s2_fall == FRAC_W'(hsvrgb_pkg::SECTOR_LEN)) || (r_s2_rise == FRAC_W'(hsvrgb_pkg::SECTOR_LEN)), "neither ramp at full scale")
    `HSVRGB_ASSERT_IMPLY(a_mix_bound, i_clk, i_rst_n, s_ctrl.valid[4], r_s4_mix0 <= MIX_W'(hsvrgb_pkg::UNIT_ONE * hsvrgb_pkg::SECTOR_LEN), "mix term above full scale")
    `HSVRGB_ASSERT_NEXT(a_stage_handoff, i_clk, i_rst_n, s_ctrl.valid[1] && s_ctrl.load[2], s_ctrl.valid[2], "request lost between stages")

endmodule

/* tb/hsvrgb_checker.sv */
// Checker for the HSV to RGB converter: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    hsvrgb_in_if   i_hsv,
    hsvrgb_out_if  i_rgb,
    output int     o_mismatches,
    output int     o_pending,
    output int     o_checked
);

    // 8-bit full-scale multiplier applied to each channel
    localparam longint unsigned FULL_SCALE = 255;
    // Only the first few mismatches get a line of their own
    localparam int MAX_REPORTS = 25;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              layer_flag;
    } t_rgb_pixel;

    t_rgb_pixel rgb_expect_q[$];
    t_rgb_pixel rgb_want;
    int         mismatch_cnt = 0;
    int         checked_cnt  = 0;
    int         pending_cnt  = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_cnt;

    // Saturation and value: negatives count as zero, above 1.0 counts as 1.0
    function automatic longint unsigned clamp_level(input logic signed [UNIT_W-1:0] x);
        longint unsigned res;
        if (x < 0) begin
            res = 0;
        end else if (x > UNIT_ONE) begin
            res = UNIT_ONE;
        end else begin
            res = longint'(x);
        end
        return res;
    endfunction

    // v * ((1-s) + s*ramp) * 255, exact, one floor at the end
    function automatic logic [CHAN_W-1:0] scale_channel(input longint unsigned v,
                                                        input longint unsigned s,
                                                        input longint unsigned r);
        longint unsigned one;
        longint unsigned sect;
        longint unsigned mix;
        longint unsigned num;
        longint unsigned den;
        one  = UNIT_ONE;
        sect = SECTOR_LEN;
        mix  = (one - s) * sect + s * r;
        num  = v * mix * FULL_SCALE;
        den  = one * one * sect;
        return CHAN_W'(num / den);
    endfunction

    // Expected pixel for one HSV request
    function automatic t_rgb_pixel predict_rgb(input logic signed [HUE_W-1:0]  hue,
                                               input logic signed [UNIT_W-1:0] sat,
                                               input logic signed [UNIT_W-1:0] bri,
                                               input logic                     layer);
        longint            h;
        longint            sect;
        longint            q;
        longint            f;
        longint            m;
        longint unsigned   s;
        longint unsigned   v;
        logic [CHAN_W-1:0] falling;
        logic [CHAN_W-1:0] rising;
        logic [CHAN_W-1:0] floor_ch;
        t_rot              rot;
        t_rgb_pixel        px;

        sect = SECTOR_LEN;
        h    = longint'(hue);
        q    = h / sect;
        f    = h % sect;
        // floor the sector so negative hues land in [0, sector)
        if (f < 0) begin
            f += sect;
            q -= 1;
        end
        s = clamp_level(sat);
        v = clamp_level(bri);

        falling  = scale_channel(v, s, (2 * (sect - f) < sect) ? 2 * (sect - f) : sect);
        rising   = scale_channel(v, s, (2 * f < sect) ? 2 * f : sect);
        floor_ch = scale_channel(v, s, 0);

        // non-negative residue of the sector picks the rotation
        m   = ((q % 3) + 3) % 3;
        rot = t_rot'(m[1:0]);
        case (rot)
            ROT_0: begin
                px.red   = falling;
                px.green = rising;
                px.blue  = floor_ch;
            end
            ROT_1: begin
                px.red   = floor_ch;
                px.green = falling;
                px.blue  = rising;
            end
            default: begin
                px.red   = rising;
                px.green = floor_ch;
                px.blue  = falling;
            end
        endcase
        px.layer_flag = layer;
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Requests in, results out; results compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_hsv.valid && i_hsv.ready) begin
                rgb_expect_q.push_back(predict_rgb(i_hsv.hue, i_hsv.saturation,
                                                   i_hsv.brightness, i_hsv.layer_select));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                if (rgb_expect_q.size() == 0) begin
                    report_mismatch("result with no request pending (rgb)",
                                    int'({i_rgb.red, i_rgb.green, i_rgb.blue}), 0);
                end else begin
                    rgb_want = rgb_expect_q.pop_front();
                    checked_cnt++;
                    if (i_rgb.red !== rgb_want.red)
                        report_mismatch("red", int'(i_rgb.red), int'(rgb_want.red));
                    if (i_rgb.green !== rgb_want.green)
                        report_mismatch("green", int'(i_rgb.green), int'(rgb_want.green));
                    if (i_rgb.blue !== rgb_want.blue)
                        report_mismatch("blue", int'(i_rgb.blue), int'(rgb_want.blue));
                    if (i_rgb.layer_flag !== rgb_want.layer_flag)
                        report_mismatch("layer_flag", int'(i_rgb.layer_flag),
                                        int'(rgb_want.layer_flag));
                end
            end
        end
        pending_cnt <= rgb_expect_q.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the HSV to RGB converter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import hsvrgb_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1530;
    localparam int IDLE_LIMIT   = 2000;
    localparam int CALM_BLOCK   = 100;
    // Hue step between ramp corners (half a sector)
    localparam int HALF_SECTOR  = SECTOR_LEN / 2;

    logic i_clk;
    logic i_rst_n;

    hsvrgb_in_if  hsv_ch();
    hsvrgb_out_if rgb_ch();

    int mismatches;
    int pending;
    int checked;

    int sent_cnt      = 0;
    int directed_cnt  = 0;
    int neg_hue_cnt   = 0;
    int low_clamp_cnt = 0;
    int high_clamp_cnt = 0;
    int idle_cycles   = 0;
    int calm_left     = 0;
    int stall_left    = 0;
    logic sender_calm = 1'b0;

    logic signed [HUE_W-1:0] rand_hue;
    int hue_pick;
    int sat_pick;
    int bri_pick;

    hsv_to_rgb_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (hsv_ch),
        .o_out   (rgb_ch)
    );

    hsvrgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hsv        (hsv_ch),
        .i_rgb        (rgb_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else if (r < 98)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 60);
        return n;
    endfunction

    // Saturation or value: mostly in range, some at the clamp corners, some any 10 bits
    function automatic int pick_level();
        logic signed [UNIT_W-1:0] x;
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            x = UNIT_W'($urandom());
        end else if (r < 30) begin
            case ($urandom_range(0, 5))
                0:       x = UNIT_W'(-1);
                1:       x = UNIT_W'(0);
                2:       x = UNIT_W'(1);
                3:       x = UNIT_W'(UNIT_ONE - 1);
                4:       x = UNIT_W'(UNIT_ONE);
                default: x = UNIT_W'(UNIT_ONE + 1);
            endcase
        end else begin
            x = UNIT_W'($urandom_range(0, UNIT_ONE));
        end
        return int'(x);
    endfunction

    // One request: hold it until accepted, then maybe leave a gap
    task automatic send_hsv(input int hue, input int sat, input int bri, input logic layer);
        int gap;
        hsv_ch.valid        <= 1'b1;
        hsv_ch.hue          <= HUE_W'(hue);
        hsv_ch.saturation   <= UNIT_W'(sat);
        hsv_ch.brightness   <= UNIT_W'(bri);
        hsv_ch.layer_select <= layer;
        sent_cnt++;
        if (hue < 0) neg_hue_cnt++;
        if (sat < 0 || bri < 0) low_clamp_cnt++;
        if (sat > UNIT_ONE || bri > UNIT_ONE) high_clamp_cnt++;
        @(posedge i_clk);
        while (!hsv_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            hsv_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Result side: random stalls with occasional long stretches of steady ready
    initial begin
        rgb_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left > 0) begin
                rgb_ch.ready <= 1'b1;
                calm_left--;
            end else if (stall_left > 0) begin
                rgb_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rgb_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 2)
                    calm_left = $urandom_range(100, 300);
                else
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results pending",
                     idle_cycles, pending);
            $display("** hsv_to_rgb_converter: FAILED **");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n             = 1'b0;
        hsv_ch.valid        = 1'b0;
        hsv_ch.hue          = '0;
        hsv_ch.saturation   = '0;
        hsv_ch.brightness   = '0;
        hsv_ch.layer_select = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: sector starts and ends, rotations, hue extremes, clamping
        send_hsv(0, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(0, 0, UNIT_ONE, 1'b1);
        send_hsv(0, 0, 0, 1'b0);
        send_hsv(HALF_SECTOR, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(HALF_SECTOR - 1, UNIT_ONE, UNIT_ONE, 1'b1);
        send_hsv(SECTOR_LEN - 1, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(SECTOR_LEN, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(2 * SECTOR_LEN, UNIT_ONE, UNIT_ONE, 1'b1);
        send_hsv(3 * SECTOR_LEN, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(-1, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(-SECTOR_LEN, UNIT_ONE, UNIT_ONE, 1'b1);
        send_hsv(-SECTOR_LEN - 1, 200, 200, 1'b0);
        send_hsv(-32768, UNIT_ONE, UNIT_ONE, 1'b0);
        send_hsv(32767, UNIT_ONE, UNIT_ONE, 1'b1);
        send_hsv(1000, -512, UNIT_ONE, 1'b0);
        send_hsv(1000, 511, UNIT_ONE, 1'b0);
        send_hsv(1000, UNIT_ONE, -512, 1'b1);
        send_hsv(1000, UNIT_ONE, 511, 1'b0);
        send_hsv(1000, -1, UNIT_ONE + 1, 1'b0);
        send_hsv(1000, UNIT_ONE + 1, -1, 1'b1);
        send_hsv(HALF_SECTOR / 2, 128, UNIT_ONE - 1, 1'b0);
        send_hsv(3 * HALF_SECTOR, UNIT_ONE - 1, 1, 1'b1);
        send_hsv(-20000, 100, 511, 1'b0);
        send_hsv(12345, 1, UNIT_ONE, 1'b1);
        directed_cnt = sent_cnt;

        // random: full-range hues, hues around ramp corners, and a narrow band
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % CALM_BLOCK == 0) sender_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0, 1: begin
                    rand_hue = HUE_W'($urandom());
                    hue_pick = int'(rand_hue);
                end
                2: hue_pick = int'($urandom_range(0, 16)) * HALF_SECTOR - 8 * HALF_SECTOR
                              + int'($urandom_range(0, 8)) - 4;
                default: hue_pick = int'($urandom_range(0, 2 * SECTOR_LEN - 1)) - SECTOR_LEN;
            endcase
            sat_pick = pick_level();
            bri_pick = pick_level();
            send_hsv(hue_pick, sat_pick, bri_pick, 1'($urandom_range(0, 1)));
        end
        sender_calm = 1'b0;
        hsv_ch.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 4) @(posedge i_clk);

        $display("Sent %0d HSV requests (%0d directed), %0d RGB results checked.",
                 sent_cnt, directed_cnt, checked);
        $display("Coverage: %0d negative hues, %0d with a level below zero, %0d above 1.0.",
                 neg_hue_cnt, low_clamp_cnt, high_clamp_cnt);
        if (mismatches == 0 && pending == 0) begin
            $display("** hsv_to_rgb_converter: PASSED **");
        end else begin
            $display("** hsv_to_rgb_converter: FAILED **");
        end
        $finish;
    end

endmodule

/* hsv_to_rgb_converter.f */
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_if.sv
rtl/hsvrgb_pipe_ctrl.sv
rtl/hsv_to_rgb_converter.sv
tb/hsvrgb_checker.sv
tb/testbench.sv
